// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache with pending queue.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_QUEUE   = 2'd2;

  localparam logic [2:0] KIND_HIT      = 3'd0;
  localparam logic [2:0] KIND_REQUEST  = 3'd1;
  localparam logic [2:0] KIND_REPLY    = 3'd2;
  localparam logic [2:0] KIND_PENDING  = 3'd3;
  localparam logic [2:0] KIND_QUEUED   = 3'd4;
  localparam logic [2:0] KIND_REJECTED = 3'd5;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_OWN_MAC = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  localparam logic [15:0] MIN_ARP_LEN   = 16'd28;
  localparam logic [15:0] HW_ETHER      = 16'd1;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  HW_LEN        = 8'd6;
  localparam logic [7:0]  IPV4_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'd1;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SLOTS,
    ST_REPLY,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_step;  // advance table index
    logic write_tab;  // write cache entry from scan result
    logic slot_step;  // advance slot index
    logic slot_emit;  // emit pending result at current slot
    logic emit_reply; // emit reply
    logic emit_single;// emit resolve/queue result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_ok;      // valid receive / resolve / queue command
    logic is_receive;
    logic scan_done;
    logic stored;      // table write happened (or will)
    logic slot_match;
    logic slot_last;
    logic want_reply;
    logic out_busy;    // output register full and not taken
  } stat_t;

endpackage

// ===== sv/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: table scan, slot walk, reply and single-result emission.
// ----------------------------------------------------------------------------
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (!stat.cmd_ok) state_next = ST_IDLE;
        else if (stat.scan_done) begin
          if (!stat.is_receive) state_next = ST_EMIT;
          else if (stat.stored) state_next = ST_SLOTS;
          else if (stat.want_reply) state_next = ST_REPLY;
          else state_next = ST_IDLE;
        end
      end
      ST_SLOTS: begin
        if (!(stat.slot_match && stat.out_busy) && stat.slot_last)
          state_next = stat.want_reply ? ST_REPLY : ST_IDLE;
      end
      ST_REPLY: if (!stat.out_busy) state_next = ST_IDLE;
      ST_EMIT:  if (!stat.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        // no transfer while reset is held
        in_ready  = !rst;
        ctrl.load = in_valid && !rst;
      end
      ST_SCAN: begin
        ctrl.scan_step = stat.cmd_ok && !stat.scan_done;
        ctrl.write_tab = stat.cmd_ok && stat.scan_done && stat.is_receive;
      end
      ST_SLOTS: begin
        ctrl.slot_emit = stat.slot_match && !stat.out_busy;
        ctrl.slot_step = !(stat.slot_match && stat.out_busy);
      end
      ST_REPLY: ctrl.emit_reply  = !stat.out_busy;
      ST_EMIT:  ctrl.emit_single = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== sv/arpc_datapath.sv =====
// ----------------------------------------------------------------------------
// arpc_datapath
// Cache and slot storage, captured item, scan index and output register.
// ----------------------------------------------------------------------------
module arpc_datapath
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int PENDING_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic [1:0]  cmd,
  input  logic [15:0] byte_count,
  input  logic [15:0] hw_type,
  input  logic [15:0] ptype,
  input  logic [7:0]  hw_addr_len,
  input  logic [7:0]  proto_addr_len,
  input  logic [15:0] op_code,
  input  logic [31:0] src_ip,
  input  logic [47:0] src_mac,
  input  logic [31:0] tgt_ip,
  input  logic [31:0] query_ip,
  input  logic [7:0]  packet_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] dest_ip,
  output logic [47:0] dest_mac,
  output logic [7:0]  out_handle,
  output logic        last
);

  localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] max_len;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [31:0] entry_ip  [TABLE_ENTRIES];
  logic [47:0] entry_mac [TABLE_ENTRIES];
  logic [PENDING_SLOTS-1:0] slot_valid;
  logic [31:0] slot_ip     [PENDING_SLOTS];
  logic [7:0]  slot_handle [PENDING_SLOTS];

  // captured item
  logic [1:0]  c_cmd;
  logic        c_ok, c_reply, c_qok;
  logic [31:0] c_ip;
  logic [47:0] c_mac;
  logic [7:0]  c_handle;

  // scan state
  logic [TW:0] tidx;
  logic        hit, free_found;
  logic [TW-1:0] hit_idx, free_idx;
  logic [SW:0] sidx;

  logic [SW-1:0] sptr;
  logic [TW-1:0] tptr;
  assign sptr = sidx[SW-1:0];
  assign tptr = tidx[TW-1:0];

  logic [SW:0] open_slot;
  logic        slot_free_any;
  always_comb begin
    open_slot = '0;
    slot_free_any = 1'b0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        open_slot = (SW+1)'(i);
        slot_free_any = 1'b1;
      end
    end
  end

  // a match at slot j releases
  logic [PENDING_SLOTS-1:0] smatch;
  always_comb
    for (int j = 0; j < PENDING_SLOTS; j++)
      smatch[j] = slot_valid[j] && (slot_ip[j] == c_ip);

  logic more;
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < PENDING_SLOTS; j++)
      if (j > int'(sptr) && smatch[j]) more = 1'b1;
  end

  logic scan_done;
  assign scan_done = (tidx == (TW+1)'(TABLE_ENTRIES)) || hit;

  assign stat.cmd_ok     = c_ok;
  assign stat.is_receive = (c_cmd == CMD_RECEIVE);
  assign stat.scan_done  = scan_done;
  assign stat.stored     = hit || free_found;
  assign stat.slot_match = smatch[sptr];
  assign stat.slot_last  = (sidx == (SW+1)'(PENDING_SLOTS - 1)) ||
                           !(more || (smatch[sptr] && out_valid && !out_ready));
  assign stat.want_reply = c_reply;
  assign stat.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
      own_mac <= '0;
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_IP:  own_ip  <= cfg_data[31:0];
        REG_OWN_MAC: own_mac <= cfg_data;
        REG_MAX_LEN: max_len <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic tab_valid_here;
  assign tab_valid_here = entry_valid[tptr];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_cmd <= cmd;
      c_handle <= packet_handle;
      if (cmd == CMD_RECEIVE) begin
        c_ip <= src_ip;
        c_mac <= src_mac;
        c_ok <= !(byte_count < MIN_ARP_LEN) && hw_type == HW_ETHER &&
                ptype == PROTO_IPV4 && hw_addr_len == HW_LEN &&
                proto_addr_len == IPV4_ADDR_LEN;
        c_reply <= (op_code == OP_REQUEST) && (tgt_ip == own_ip);
      end else begin
        c_ip <= query_ip;
        c_mac <= '0;
        c_ok <= (cmd == CMD_RESOLVE) || (cmd == CMD_QUEUE);
        c_reply <= 1'b0;
      end
      c_qok <= !(byte_count > max_len);
      tidx <= '0;
      sidx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end
    if (ctrl.scan_step) begin
      tidx <= tidx + 1'b1;
      if (tab_valid_here && entry_ip[tptr] == c_ip) begin
        hit <= 1'b1;
        hit_idx <= tptr;
      end else if (!tab_valid_here && !free_found) begin
        free_found <= 1'b1;
        free_idx <= tptr;
      end
    end
    if (ctrl.slot_step) sidx <= sidx + 1'b1;
  end

  // cache store
  always_ff @(posedge clk) begin
    if (rst) entry_valid <= '0;
    else if (ctrl.write_tab && !hit && free_found) entry_valid[free_idx] <= 1'b1;
    if (ctrl.write_tab) begin
      if (hit) entry_mac[hit_idx] <= c_mac;
      else if (free_found) begin
        entry_ip[free_idx]  <= c_ip;
        entry_mac[free_idx] <= c_mac;
      end
    end
  end

  logic queue_ok;
  assign queue_ok = c_qok && slot_free_any;

  always_ff @(posedge clk) begin
    if (rst) slot_valid <= '0;
    else begin
      if (ctrl.slot_emit) slot_valid[sptr] <= 1'b0;
      if (ctrl.emit_single && c_cmd == CMD_QUEUE && queue_ok)
        slot_valid[open_slot[SW-1:0]] <= 1'b1;
    end
    if (ctrl.emit_single && c_cmd == CMD_QUEUE && queue_ok) begin
      slot_ip[open_slot[SW-1:0]]     <= c_ip;
      slot_handle[open_slot[SW-1:0]] <= c_handle;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.slot_emit || ctrl.emit_reply || ctrl.emit_single) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (ctrl.slot_emit) begin
      kind <= KIND_PENDING;
      dest_ip <= c_ip;
      dest_mac <= c_mac;
      out_handle <= slot_handle[sptr];
      last <= !more && !c_reply;
    end else if (ctrl.emit_reply) begin
      kind <= KIND_REPLY;
      dest_ip <= c_ip;
      dest_mac <= c_mac;
      out_handle <= '0;
      last <= 1'b1;
    end else if (ctrl.emit_single) begin
      dest_ip <= c_ip;
      last <= 1'b1;
      if (c_cmd == CMD_RESOLVE) begin
        kind <= hit ? KIND_HIT : KIND_REQUEST;
        dest_mac <= hit ? entry_mac[hit_idx] : 48'd0;
        out_handle <= '0;
      end else begin
        kind <= queue_ok ? KIND_QUEUED : KIND_REJECTED;
        dest_mac <= '0;
        out_handle <= c_handle;
      end
    end
  end

  // a released slot must have matched the sender
  assert property (@(posedge clk) disable iff (rst)
    ctrl.slot_emit |-> smatch[sptr]) else $error("release of non-matching slot");
  // never overwrite a result still waiting
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(ctrl.slot_emit || ctrl.emit_reply || ctrl.emit_single))
    else $error("output overrun");
  // one emit source at a time
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.slot_emit, ctrl.emit_reply, ctrl.emit_single}))
    else $error("multiple emit commands");

endmodule

// ===== sv/arp_cache_with_pending_queue_unit.sv =====
// ----------------------------------------------------------------------------
// arp_cache_with_pending_queue_unit
// ARP offload: address cache, pending packet queue, request/reply generation.
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// input    | in_valid / in_ready   | cmd .. packet_handle
// result   | out_valid / out_ready | kind, dest_ip, dest_mac, out_handle, last
// config   | cfg_we                | cfg_index, cfg_data
//
// One item at a time. The cache is searched one entry a cycle, stopping early
// on a hit. A receive that is stored in the cache then walks the pending
// slots one a cycle while no result is stalled at a matching slot (releases
// go out during the walk), and then emits a reply if one is wanted; resolve
// and queue emit a single result after the search. Reset is synchronous; it
// clears the valid bits and the own address registers and sets max_len to
// MAX_LEN_RESET.
// A stalled result holds the slot walk at a matching slot until it is taken.
module arp_cache_with_pending_queue_unit
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int PENDING_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] byte_count,
  input  logic [15:0] hw_type,
  input  logic [15:0] ptype,
  input  logic [7:0]  hw_addr_len,
  input  logic [7:0]  proto_addr_len,
  input  logic [15:0] op_code,
  input  logic [31:0] src_ip,
  input  logic [47:0] src_mac,
  input  logic [31:0] tgt_ip,
  input  logic [31:0] query_ip,
  input  logic [7:0]  packet_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] dest_ip,
  output logic [47:0] dest_mac,
  output logic [7:0]  out_handle,
  output logic        last
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  arpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .ctrl(ctrl)
  );

  // storage and result register
  arpc_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .PENDING_SLOTS(PENDING_SLOTS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .byte_count(byte_count), .hw_type(hw_type),
    .ptype(ptype), .hw_addr_len(hw_addr_len),
    .proto_addr_len(proto_addr_len), .op_code(op_code),
    .src_ip(src_ip), .src_mac(src_mac), .tgt_ip(tgt_ip),
    .query_ip(query_ip), .packet_handle(packet_handle),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .dest_ip(dest_ip), .dest_mac(dest_mac), .out_handle(out_handle), .last(last)
  );

endmodule
